/* design/ascii_dec_hex_number_parser_defines.svh */
// ----------------------------------------------------------------------------
// ascii_dec_hex_number_parser_defines
// assertion macros shared by the fifo and back modules of the number parser
// ----------------------------------------------------------------------------
`ifndef ASCII_DEC_HEX_NUMBER_PARSER_DEFINES_SVH
`define ASCII_DEC_HEX_NUMBER_PARSER_DEFINES_SVH

// property checked on every rising clk_i edge outside reset
`define ANP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold outside reset
`define ANP_ASSERT_NEVER(lbl, cond, msg) \
  `ANP_ASSERT(lbl, !(cond), msg)

`endif

/* design/anp_pkg.sv */
// ----------------------------------------------------------------------------
// anp_pkg
// types and constants of the ascii decimal / hex number parser
// ----------------------------------------------------------------------------
package anp_pkg;

  localparam int unsigned VALUE_BITS_DEFAULT = 32;
  localparam int unsigned FIFO_DEPTH_DEFAULT = 2;
  localparam int unsigned NUMBER_BITS        = 32;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  localparam logic [3:0] LETTER_DIGIT_OFFSET = 4'd9;

  typedef struct packed {
    logic [7:0] char_code;
    logic       terminator;
  } anp_in_t;

  typedef struct packed {
    logic [NUMBER_BITS-1:0] number;
    logic                   parse_ok;
  } anp_out_t;

  typedef struct packed {
    logic       terminator;
    logic       is_dec;
    logic       is_hex_alpha;
    logic       is_x;
    logic [3:0] digit;
  } anp_cls_t;

endpackage

/* design/anp_front.sv */
// ----------------------------------------------------------------------------
// anp_front
// accepts characters and classifies them into digit class and value
// ----------------------------------------------------------------------------
module anp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  anp_pkg::anp_in_t  in_item_i,
  output logic              cls_valid_o,
  input  logic              cls_ready_i,
  output anp_pkg::anp_cls_t cls_o
);
  import anp_pkg::*;

  logic     vld_q, vld_d;
  anp_cls_t cls_q, cls_d;
  logic     take;
  logic [7:0] ch;

  assign ch     = in_item_i.char_code;
  assign full_o = vld_q && !cls_ready_i;
  assign take   = push_i && !full_o;

  always_comb begin
    cls_d.terminator   = in_item_i.terminator;
    cls_d.is_dec       = (ch >= CH_ZERO) && (ch <= CH_NINE);
    cls_d.is_hex_alpha = ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_F)) ||
                         ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_F));
    cls_d.is_x         = (ch == CH_LOWER_X) || (ch == CH_UPPER_X);
    if (cls_d.is_dec) begin
      cls_d.digit = ch[3:0];
    end else if (cls_d.is_hex_alpha) begin
      cls_d.digit = ch[3:0] + LETTER_DIGIT_OFFSET;
    end else begin
      cls_d.digit = 4'd0;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (cls_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cls_q <= cls_d;
    end
  end

  assign cls_valid_o = vld_q;
  assign cls_o       = cls_q;

endmodule

/* design/anp_fifo.sv */
// ----------------------------------------------------------------------------
// anp_fifo
// short queue between the classifying front and the accumulating back
// ----------------------------------------------------------------------------
`include "ascii_dec_hex_number_parser_defines.svh"

module anp_fifo #(
  parameter int unsigned DEPTH = anp_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              ready_o,
  input  anp_pkg::anp_cls_t data_i,
  output logic              valid_o,
  input  logic              pop_i,
  output anp_pkg::anp_cls_t data_o
);
  import anp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  anp_cls_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `ANP_ASSERT_NEVER(a_fifo_count_range, cnt_q > CW'(DEPTH), "fifo count beyond depth")

endmodule

/* design/anp_back.sv */
// ----------------------------------------------------------------------------
// anp_back
// accumulates digits in base 10 or 16 and holds the result of a token
// ----------------------------------------------------------------------------
`include "ascii_dec_hex_number_parser_defines.svh"

module anp_back #(
  parameter int unsigned VALUE_BITS = anp_pkg::VALUE_BITS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cls_valid_i,
  output logic              cls_ready_o,
  input  anp_pkg::anp_cls_t cls_i,
  output logic              empty_o,
  input  logic              pop_i,
  output anp_pkg::anp_out_t result_o
);
  import anp_pkg::*;

  localparam int unsigned PW = VALUE_BITS + 5;

  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic                  hex_q, hex_d;
  logic [1:0]            pos_q, pos_d;
  logic                  fz_q, fz_d;
  logic                  await_q, await_d;
  logic                  err_q, err_d;
  logic                  out_vld_q, out_vld_d;
  anp_out_t              out_q, out_d;

  logic                  take, is_prefix, digit_ok, ovf, ok;
  logic [PW-1:0]         acc_ext, prod;
  logic [VALUE_BITS+NUMBER_BITS-1:0] num_ext;

  assign cls_ready_o = !cls_i.terminator || !out_vld_q || pop_i;
  assign take        = cls_valid_i && cls_ready_o;

  assign acc_ext   = PW'(acc_q);
  assign prod      = (hex_q ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1)))
                     + PW'(cls_i.digit);
  assign ovf       = |prod[PW-1:VALUE_BITS];
  assign is_prefix = (pos_q == 2'd1) && fz_q && !hex_q && cls_i.is_x;
  assign digit_ok  = cls_i.is_dec || (hex_q && cls_i.is_hex_alpha);
  assign ok        = !err_q && (pos_q != 2'd0) && !await_q;
  assign num_ext   = {{NUMBER_BITS{1'b0}}, acc_q};

  always_comb begin
    acc_d     = acc_q;
    hex_d     = hex_q;
    pos_d     = pos_q;
    fz_d      = fz_q;
    await_d   = await_q;
    err_d     = err_q;
    out_vld_d = out_vld_q && !pop_i;
    out_d     = out_q;
    if (take) begin
      if (cls_i.terminator) begin
        out_vld_d      = 1'b1;
        out_d.parse_ok = ok;
        out_d.number   = ok ? num_ext[NUMBER_BITS-1:0] : '0;
        acc_d          = '0;
        hex_d          = 1'b0;
        pos_d          = 2'd0;
        fz_d           = 1'b0;
        await_d        = 1'b0;
        err_d          = 1'b0;
      end else begin
        if (pos_q != 2'd2) begin
          pos_d = pos_q + 2'd1;
        end
        if (!err_q) begin
          if (is_prefix) begin
            hex_d   = 1'b1;
            await_d = 1'b1;
            acc_d   = '0;
          end else if (!digit_ok) begin
            err_d = 1'b1;
          end else begin
            if (pos_q == 2'd0) begin
              fz_d = (cls_i.digit == 4'd0);
            end
            if (ovf) begin
              err_d = 1'b1;
            end else begin
              acc_d   = prod[VALUE_BITS-1:0];
              await_d = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      hex_q     <= 1'b0;
      pos_q     <= 2'd0;
      fz_q      <= 1'b0;
      await_q   <= 1'b0;
      err_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      hex_q     <= hex_d;
      pos_q     <= pos_d;
      fz_q      <= fz_d;
      await_q   <= await_d;
      err_q     <= err_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o  = !out_vld_q;
  assign result_o = out_q;

  `ANP_ASSERT(a_fail_gives_zero, out_vld_q && !out_q.parse_ok |-> out_q.number == '0,
              "failed parse with nonzero number")
  `ANP_ASSERT(a_await_in_hex, await_q |-> hex_q, "awaiting hex digit outside hex mode")
  `ANP_ASSERT(a_term_clears, take && cls_i.terminator |=> pos_q == 2'd0 && !err_q && !hex_q,
              "state not cleared after terminator")

endmodule

/* design/ascii_dec_hex_number_parser.sv */
// ----------------------------------------------------------------------------
// ascii_dec_hex_number_parser
// parses a decimal or 0x-prefixed hex token, one character per transaction
// ----------------------------------------------------------------------------
// channel  | handshake                 | payload
// input    | push / full  (queue push) | in_item_i  : char_code, terminator
// result   | empty / pop  (queue pop)  | result_o   : number, parse_ok
//
// one item per cycle when not stalled; a character needs one shift-add in the back stage
// a terminator's result reaches the ports through the front register, then the queue,
// then the result register
// reset clears the token state and both queues at once, no clearing pass
// a waiting result holds back the next terminator and everything queued behind it
// ----------------------------------------------------------------------------
module ascii_dec_hex_number_parser #(
  parameter int unsigned VALUE_BITS = anp_pkg::VALUE_BITS_DEFAULT,
  parameter int unsigned FIFO_DEPTH = anp_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  anp_pkg::anp_in_t  in_item_i,
  output logic              empty,
  input  logic              pop,
  output anp_pkg::anp_out_t result_o
);
  import anp_pkg::*;

  logic     f_valid, f_ready;
  anp_cls_t f_cls;
  logic     q_valid, q_ready;
  anp_cls_t q_cls;

  anp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_item_i   (in_item_i),
    .cls_valid_o (f_valid),
    .cls_ready_i (f_ready),
    .cls_o       (f_cls)
  );

  anp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .ready_o (f_ready),
    .data_i  (f_cls),
    .valid_o (q_valid),
    .pop_i   (q_ready),
    .data_o  (q_cls)
  );

  anp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (q_valid),
    .cls_ready_o (q_ready),
    .cls_i       (q_cls),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the ascii decimal / hex number parser against a cycle-free predictor:
// a short table of directed tokens, then random tokens (well-formed decimal and
// hex, values near the 32-bit limit, broken tokens and noise); the first 700 items run
// under random stalls on both queue sides
// ----------------------------------------------------------------------------
module testbench;
  import anp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned ITEM_GOAL   = 1050;
  localparam logic [63:0] VALUE_MAX   = (64'd1 << VALUE_BITS_DEFAULT) - 64'd1;

  typedef struct {
    anp_in_t  item;
    bit       typed;
    anp_out_t want;
  } stim_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     full;
  anp_in_t  in_item_i = '0;
  logic     empty;
  logic     pop = 1'b0;
  anp_out_t result_o;

  ascii_dec_hex_number_parser dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // token state of the predictor
  logic [63:0] acc_value;
  bit          in_hex;
  logic [1:0]  char_pos;
  bit          lead_zero;
  bit          need_hex_digit;
  bit          token_bad;

  anp_out_t    want_results[$];
  stim_row_t   dir_rows[$];
  logic [7:0]  token_chars[$];
  anp_out_t    oldest_want;
  int unsigned item_count;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 63;

  function automatic anp_in_t mk_item(logic [7:0] ch, logic term);
    anp_in_t it;
    it.char_code  = ch;
    it.terminator = term;
    return it;
  endfunction

  function automatic void clear_token();
    acc_value      = '0;
    in_hex         = 1'b0;
    char_pos       = '0;
    lead_zero      = 1'b0;
    need_hex_digit = 1'b0;
    token_bad      = 1'b0;
  endfunction

  function automatic void parse_char(logic [7:0] ch);
    logic [1:0]  p;
    logic [63:0] base;
    logic [63:0] dig;
    bit          legal;
    p     = char_pos;
    base  = in_hex ? 64'd16 : 64'd10;
    dig   = '0;
    legal = 1'b1;
    if (char_pos < 2'd2) char_pos = char_pos + 2'd1;
    if (token_bad) return;
    if (p == 2'd1 && lead_zero && !in_hex && (ch == CH_LOWER_X || ch == CH_UPPER_X)) begin
      in_hex         = 1'b1;
      need_hex_digit = 1'b1;
      acc_value      = '0;
      return;
    end
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      dig = 64'(ch - CH_ZERO);
    end else if (in_hex && ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
      dig = 64'd10 + 64'(ch - CH_LOWER_A);
    end else if (in_hex && ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
      dig = 64'd10 + 64'(ch - CH_UPPER_A);
    end else begin
      legal = 1'b0;
    end
    if (!legal) begin
      token_bad = 1'b1;
      return;
    end
    if (p == 2'd0) lead_zero = (dig == 64'd0);
    if (acc_value > VALUE_MAX / base || acc_value * base > VALUE_MAX - dig) begin
      token_bad = 1'b1;
      return;
    end
    acc_value      = acc_value * base + dig;
    need_hex_digit = 1'b0;
  endfunction

  function automatic anp_out_t finish_token();
    anp_out_t r;
    bit       good;
    good       = !token_bad && char_pos != 2'd0 && !need_hex_digit;
    r.number   = good ? acc_value[NUMBER_BITS-1:0] : '0;
    r.parse_ok = good;
    clear_token();
    return r;
  endfunction

  function automatic void take_item(anp_in_t it, bit typed, anp_out_t want);
    anp_out_t r;
    item_count++;
    if (it.terminator) begin
      r = finish_token();
      want_results.push_back(typed ? want : r);
    end else begin
      parse_char(it.char_code);
    end
    if (item_count >= 700) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (item_count >= 350) begin
      send_idle_pct = 63;
      recv_idle_pct = 38;
    end
  endfunction

  task automatic send_item(anp_in_t it, bit typed, anp_out_t want);
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < send_idle_pct) begin
        push <= 1'b0;
      end else begin
        push      <= 1'b1;
        in_item_i <= it;
        @(posedge clk_i);
        if (!full) begin
          done = 1'b1;
          take_item(it, typed, want);
        end
      end
    end
  endtask

  function automatic void add_row(logic [7:0] ch, logic term, bit typed,
                                  logic [31:0] num, logic ok);
    stim_row_t row;
    row.item          = mk_item(ch, term);
    row.typed         = typed;
    row.want.number   = num;
    row.want.parse_ok = ok;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned d;
    d = $urandom_range(0, 15);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(d - 10);
  endfunction

  function automatic void add_prefix();
    token_chars.push_back(CH_ZERO);
    token_chars.push_back($urandom_range(0, 1) ? CH_UPPER_X : CH_LOWER_X);
  endfunction

  function automatic void build_wellformed();
    int unsigned n;
    if ($urandom_range(0, 1)) begin
      n = $urandom_range(1, 10);
      repeat (n) token_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end else begin
      add_prefix();
      n = $urandom_range(1, 9);
      repeat (n) token_chars.push_back(hex_char());
    end
  endfunction

  function automatic void build_token();
    int unsigned kind;
    int unsigned n;
    token_chars.delete();
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      build_wellformed();
    end else if (kind < 65) begin
      if ($urandom_range(0, 1)) begin
        add_str("429496729");
        token_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end else begin
        add_prefix();
        n = $urandom_range(0, 3);
        repeat (n) token_chars.push_back(CH_ZERO);
        repeat (8) token_chars.push_back($urandom_range(0, 1) ? CH_UPPER_F : CH_LOWER_F);
        if ($urandom_range(0, 1)) token_chars.push_back(hex_char());
      end
    end else if (kind < 75) begin
      build_wellformed();
      token_chars.insert($urandom_range(0, token_chars.size()), 8'($urandom_range(0, 255)));
    end else if (kind < 85) begin
      n = $urandom_range(0, 4);
      repeat (n) token_chars.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 90) begin
      if ($urandom_range(0, 1)) add_prefix();
    end else begin
      case ($urandom_range(0, 4))
        0: add_str("x");
        1: add_str("1x5");
        2: add_str("00x");
        3: add_str("0x0x");
        default: add_str("0XX");
      endcase
    end
  endfunction

  // result side: random pop, check each transaction against the oldest expectation
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (want_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual number=%h parse_ok=%b",
                 $time, result_o.number, result_o.parse_ok);
        mismatches++;
      end else begin
        oldest_want = want_results.pop_front();
        if (result_o.number !== oldest_want.number) begin
          $display("%0t: number mismatch, expected %h, actual %h",
                   $time, oldest_want.number, result_o.number);
          mismatches++;
        end
        if (result_o.parse_ok !== oldest_want.parse_ok) begin
          $display("%0t: parse_ok mismatch, expected %b, actual %b",
                   $time, oldest_want.parse_ok, result_o.parse_ok);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, want_results.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    clear_token();
    item_count = 0;
    mismatches = 0;
    cycle_count = 0;

    // empty token
    add_row(8'h00, 1'b1, 1'b1, 32'h0, 1'b0);
    // single zero, smallest value
    add_row(CH_ZERO, 1'b0, 1'b0, '0, 1'b0);
    add_row(8'hFF, 1'b1, 1'b1, 32'h0, 1'b1);
    // bare prefix
    add_row(CH_ZERO, 1'b0, 1'b0, '0, 1'b0);
    add_row(CH_LOWER_X, 1'b0, 1'b0, '0, 1'b0);
    add_row(8'h5A, 1'b1, 1'b1, 32'h0, 1'b0);
    // hex with mixed letter case
    add_row(CH_ZERO, 1'b0, 1'b0, '0, 1'b0);
    add_row(CH_UPPER_X, 1'b0, 1'b0, '0, 1'b0);
    add_row(CH_LOWER_F, 1'b0, 1'b0, '0, 1'b0);
    add_row(CH_UPPER_A, 1'b0, 1'b0, '0, 1'b0);
    add_row(CH_NINE, 1'b0, 1'b0, '0, 1'b0);
    add_row(8'h00, 1'b1, 1'b0, '0, 1'b0);
    // x not after a leading zero
    add_row(CH_LOWER_X, 1'b0, 1'b0, '0, 1'b0);
    add_row(CH_ZERO + 8'd1, 1'b0, 1'b0, '0, 1'b0);
    add_row(8'hA5, 1'b1, 1'b1, 32'h0, 1'b0);
    // code zero
    add_row(8'h00, 1'b0, 1'b0, '0, 1'b0);
    add_row(8'h00, 1'b1, 1'b1, 32'h0, 1'b0);
    // code above 127, then digits ignored after the error
    add_row(8'hFF, 1'b0, 1'b0, '0, 1'b0);
    add_row(CH_ZERO + 8'd7, 1'b0, 1'b0, '0, 1'b0);
    add_row(8'h3C, 1'b1, 1'b1, 32'h0, 1'b0);
    // hex letter in decimal mode
    add_row(CH_LOWER_A + 8'd1, 1'b0, 1'b0, '0, 1'b0);
    add_row(8'h7F, 1'b1, 1'b1, 32'h0, 1'b0);
    // x as third character
    add_row(CH_ZERO, 1'b0, 1'b0, '0, 1'b0);
    add_row(CH_ZERO + 8'd7, 1'b0, 1'b0, '0, 1'b0);
    add_row(CH_UPPER_X, 1'b0, 1'b0, '0, 1'b0);
    add_row(8'hC3, 1'b1, 1'b1, 32'h0, 1'b0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    while (item_count < ITEM_GOAL) begin
      build_token();
      foreach (token_chars[i]) send_item(mk_item(token_chars[i], 1'b0), 1'b0, '0);
      send_item(mk_item(8'($urandom_range(0, 255)), 1'b1), 1'b0, '0);
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (want_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
